// ===== src/l3d_pkg.sv =====
// l3d_pkg: shared widths, codes and item types of the 3d line unit
// used by line3d_point_intersect_distance_unit, depends on nothing
package l3d_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIST_WIDTH  = COORD_WIDTH - 1;
    localparam int MUL_LAT     = 3;     // register stages from operands to product in l3d_mult
    localparam int MUL_CHUNK   = 17;    // partial product slice width
    localparam int APB_AW      = 5;

    // query modes
    localparam logic [1:0] MODE_POINT  = 2'd0;
    localparam logic [1:0] MODE_ISECT  = 2'd1;
    localparam logic [1:0] MODE_DIST   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;  // no query, all-zero result

    // register indexes
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [2:0] REG_DIRECTION_X = 3'd3;
    localparam logic [2:0] REG_DIRECTION_Y = 3'd4;
    localparam logic [2:0] REG_DIRECTION_Z = 3'd5;

    typedef struct packed {
        logic [1:0]                    mode;
        logic signed [COORD_WIDTH-1:0] param;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] result_x;
        logic signed [COORD_WIDTH-1:0] result_y;
        logic signed [COORD_WIDTH-1:0] result_z;
        logic [DIST_WIDTH-1:0]         distance;
        logic                          degenerate;
        logic                          saturated;
    } t_result;

endpackage

// ===== src/l3d_mult.sv =====
// l3d_mult: pipelined unsigned multiplier built from narrow partial products
// three register stages (products, row sums, total), no package dependency
module l3d_mult #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int K  = 17
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_a,
    input  logic [BW-1:0]     i_b,
    output logic [AW+BW-1:0]  o_p
);

    localparam int NA   = (AW + K - 1) / K;
    localparam int NB   = (BW + K - 1) / K;
    localparam int ROWW = (NB + 1) * K;
    localparam int PW   = (NA + NB) * K;

    logic [NA*K-1:0] a_pad;
    logic [NB*K-1:0] b_pad;
    logic [2*K-1:0]  n_pp  [NA][NB];
    logic [2*K-1:0]  r_pp  [NA][NB];
    logic [ROWW-1:0] n_row [NA];
    logic [ROWW-1:0] r_row [NA];
    logic [PW-1:0]   n_p;
    logic [PW-1:0]   r_p;

    assign a_pad = (NA*K)'(i_a);
    assign b_pad = (NB*K)'(i_b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_pp[i][j] = (2*K)'(a_pad[i*K +: K]) * (2*K)'(b_pad[j*K +: K]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (ROWW'(r_pp[i][j]) << (j*K));
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            n_p = n_p + (PW'(r_row[i]) << (i*K));
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp  <= n_pp;
        r_row <= n_row;
        r_p   <= n_p;
    end

    assign o_p = r_p[AW+BW-1:0];

endmodule

// ===== src/line3d_point_intersect_distance_unit.sv =====
// line3d_point_intersect_distance_unit: 3d line queries in signed fixed point
// depends on l3d_pkg and l3d_mult
//
// usage
//   origin and direction are written over the apb port (byte address 4*index)
//   an item is taken at a rising edge with start high and busy low; busy is
//   always low, so one item can enter in every cycle
//   mode point: origin + param*direction, offsets rounded to nearest
//   mode isect: point at z = origin z + param, degenerate if dz is zero
//   mode dist: floor of the perpendicular distance from the point to the line
//   each result shows on o_result for one cycle with o_done high
//   latency is the same for every mode; it is set by the distance path:
//   a quotient pipeline of 2*(COORD_WIDTH-1) one-bit steps followed by a
//   square root pipeline of COORD_WIDTH-1 steps
//   throughput is one item per cycle, results leave in the order items enter
//   reset zeroes config, side and done registers, emptying the pipeline;
//   data registers are not reset; the receiver cannot stall, so it never holds
module line3d_point_intersect_distance_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item channel
    input  logic                        start,
    input  l3d_pkg::t_item              i_item,
    output logic                        busy,
    output logic                        o_done,
    output l3d_pkg::t_result            o_result,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [l3d_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int W   = l3d_pkg::COORD_WIDTH;
    localparam int D   = W - 1;          // distance bits
    localparam int CW  = W + 1;          // point minus origin
    localparam int XW  = 2*W + 2;        // cross product component magnitude
    localparam int NW  = 2*XW + 2;       // numerator |c x d|^2
    localparam int MW  = 2*W + 2;        // denominator |d|^2
    localparam int QW  = 2*D;            // quotient bits
    localparam int EW  = 2*W + 3;        // exact sum before clamping
    localparam int RW  = D + 2;          // square root remainder
    localparam int K   = l3d_pkg::MUL_CHUNK;
    localparam int ML  = l3d_pkg::MUL_LAT;

    // stage numbers, counted from the input register
    localparam int S0_RES  = ML + 1;
    localparam int S1_Q    = ML + 2*W;
    localparam int S1_RES  = S1_Q + 1;
    localparam int S2_C    = 1;
    localparam int S2_X    = S2_C + ML;
    localparam int S2_XM   = S2_X + 1;
    localparam int S2_N    = S2_XM + ML + 1;
    localparam int S2_INIT = S2_N + 1;
    localparam int S2_Q    = S2_INIT + QW;
    localparam int LAST    = S2_Q + D;

    localparam logic [EW-1:0] HALF = EW'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic                vld;
        logic [1:0]          mode;
        logic [2:0]          neg0;     // sign of param*d per axis
        logic [1:0]          neg1;     // sign of z*d/dz for x and y
        logic                deg1;     // dz is zero
        logic                deg2;     // whole direction is zero
        logic                z_clip;
        logic [W-1:0]        z_res;    // origin z + z, saturated
    } t_side;

    typedef struct packed {
        logic [2:0][W-1:0]   v;
        logic                clip;
    } t_pt3;

    typedef struct packed {
        logic [1:0][W-1:0]   v;
        logic                clip;
    } t_pt2;

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    // saturate to the signed coordinate range, clip flag on top
    function automatic logic [W:0] clamp_w(input logic signed [EW-1:0] v);
        logic [EW-W:0] hi;
        hi = v[EW-1:W-1];
        if (hi == '0 || hi == '1) begin
            return {1'b0, v[W-1:0]};
        end
        return {1'b1, v[EW-1], {(W-1){~v[EW-1]}}};
    endfunction

    // origin plus signed offset given as magnitude and sign
    function automatic logic [W:0] place(input logic signed [W-1:0] org,
                                         input logic [EW-1:0] m, input logic neg);
        logic signed [EW-1:0] s;
        s = neg ? -signed'(m) : signed'(m);
        return clamp_w(EW'(org) + s);
    endfunction

    // configuration registers
    logic signed [W-1:0] r_org [3];
    logic signed [W-1:0] r_dir [3];
    logic [W-1:0]        dz;

    // pipeline registers
    l3d_pkg::t_item      r_in;
    t_side               n_sd0;
    t_side               r_sd   [0:LAST];
    t_pt3                n_m0;
    t_pt3                r_m0   [S0_RES:LAST];
    t_pt2                n_m1;
    t_pt2                r_m1   [S1_RES:LAST];
    logic [2*W-1:0]      p0     [3];
    logic [W-1:0]        n_dv_rem [2][1:2*W];
    logic [W-1:0]        r_dv_rem [2][1:2*W];
    logic [2*W-1:0]      n_dv_dq  [2][1:2*W];
    logic [2*W-1:0]      r_dv_dq  [2][1:2*W];
    logic signed [W-1:0] pt     [3];
    logic signed [CW-1:0] n_c   [3];
    logic signed [CW-1:0] r_c   [S2_C:S2_X][3];
    logic [2*XW-1:0]     sq     [3];
    logic [2*W-1:0]      msq    [3];
    logic [MW-1:0]       r_msum;
    logic [NW-1:0]       r_n;
    logic [MW-1:0]       m_n;
    logic [MW-1:0]       n_qd_rem [0:QW];
    logic [MW-1:0]       r_qd_rem [0:QW];
    logic [QW-1:0]       n_qd_dq  [0:QW];
    logic [QW-1:0]       r_qd_dq  [0:QW];
    logic                n_sat;
    logic                r_sat  [S2_INIT:LAST];
    logic [RW-1:0]       n_sq_rem  [1:D];
    logic [RW-1:0]       r_sq_rem  [1:D];
    logic [D-1:0]        n_sq_root [1:D];
    logic [D-1:0]        r_sq_root [1:D];
    logic [QW-1:0]       n_sq_q    [1:D];
    logic [QW-1:0]       r_sq_q    [1:D];
    l3d_pkg::t_result    n_out;
    l3d_pkg::t_result    r_out;
    logic                r_done;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign dz     = mag_w(r_dir[2]);

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
                r_dir[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            case (paddr[l3d_pkg::APB_AW-1:2])
                l3d_pkg::REG_ORIGIN_X:    r_org[0] <= pwdata[W-1:0];
                l3d_pkg::REG_ORIGIN_Y:    r_org[1] <= pwdata[W-1:0];
                l3d_pkg::REG_ORIGIN_Z:    r_org[2] <= pwdata[W-1:0];
                l3d_pkg::REG_DIRECTION_X: r_dir[0] <= pwdata[W-1:0];
                l3d_pkg::REG_DIRECTION_Y: r_dir[1] <= pwdata[W-1:0];
                l3d_pkg::REG_DIRECTION_Z: r_dir[2] <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[l3d_pkg::APB_AW-1:2])
            l3d_pkg::REG_ORIGIN_X:    prdata = 32'(r_org[0]);
            l3d_pkg::REG_ORIGIN_Y:    prdata = 32'(r_org[1]);
            l3d_pkg::REG_ORIGIN_Z:    prdata = 32'(r_org[2]);
            l3d_pkg::REG_DIRECTION_X: prdata = 32'(r_dir[0]);
            l3d_pkg::REG_DIRECTION_Y: prdata = 32'(r_dir[1]);
            l3d_pkg::REG_DIRECTION_Z: prdata = 32'(r_dir[2]);
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- input stage
    // signs, degenerate flags and the isect z coordinate travel with the item
    always_comb begin
        logic [W:0] zc;
        zc = clamp_w(EW'(r_org[2]) + EW'(i_item.param));
        n_sd0.vld    = start && !busy;
        n_sd0.mode   = i_item.mode;
        for (int i = 0; i < 3; i++) begin
            n_sd0.neg0[i] = i_item.param[W-1] ^ r_dir[i][W-1];
        end
        for (int i = 0; i < 2; i++) begin
            n_sd0.neg1[i] = i_item.param[W-1] ^ r_dir[i][W-1] ^ r_dir[2][W-1];
        end
        n_sd0.deg1   = (r_dir[2] == '0);
        n_sd0.deg2   = (r_dir[0] == '0) && (r_dir[1] == '0) && (r_dir[2] == '0);
        n_sd0.z_clip = zc[W];
        n_sd0.z_res  = zc[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_sd[k] <= '0;
            end
        end else begin
            r_sd[0] <= n_sd0;
            for (int k = 1; k <= LAST; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    // --------------------------------------------- |param| * |d| per axis
    // shared by mode point (all axes) and mode isect (x and y)
    for (genvar i = 0; i < 3; i++) begin : g_p0
        l3d_mult #(.AW(W), .BW(W), .K(K)) u_mul (
            .i_clk (i_clk),
            .i_a   (mag_w(r_in.param)),
            .i_b   (mag_w(r_dir[i])),
            .o_p   (p0[i])
        );
    end

    // mode point: round the offset, add the origin, saturate
    always_comb begin
        logic [W:0] pl;
        n_m0.clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            pl = place(r_org[i], (EW'(p0[i]) + HALF) >> FRAC_BITS, r_sd[ML].neg0[i]);
            n_m0.v[i] = pl[W-1:0];
            n_m0.clip = n_m0.clip | pl[W];
        end
    end

    // mode isect: restoring division of |z*d| by |dz|, one quotient bit a stage
    always_comb begin
        logic [W-1:0]   pr;
        logic [2*W-1:0] pq;
        logic [W:0]     t;
        for (int l = 0; l < 2; l++) begin
            for (int k = 1; k <= 2*W; k++) begin
                if (k == 1) begin
                    pr = '0;
                    pq = p0[l];
                end else begin
                    pr = r_dv_rem[l][k-1];
                    pq = r_dv_dq[l][k-1];
                end
                t = {pr, pq[2*W-1]};
                if (t >= {1'b0, dz}) begin
                    n_dv_rem[l][k] = W'(t - {1'b0, dz});
                    n_dv_dq[l][k]  = {pq[2*W-2:0], 1'b1};
                end else begin
                    n_dv_rem[l][k] = t[W-1:0];
                    n_dv_dq[l][k]  = {pq[2*W-2:0], 1'b0};
                end
            end
        end
    end

    // round half away from zero on the remainder, then place
    always_comb begin
        logic [W:0] pl;
        logic       up;
        n_m1.clip = 1'b0;
        for (int l = 0; l < 2; l++) begin
            up = ({r_dv_rem[l][2*W], 1'b0} >= {1'b0, dz});
            pl = place(r_org[l], EW'(r_dv_dq[l][2*W]) + EW'(up), r_sd[S1_Q].neg1[l]);
            n_m1.v[l] = pl[W-1:0];
            n_m1.clip = n_m1.clip | pl[W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_rem <= n_dv_rem;
        r_dv_dq  <= n_dv_dq;
        r_m0[S0_RES] <= n_m0;
        for (int k = S0_RES + 1; k <= LAST; k++) begin
            r_m0[k] <= r_m0[k-1];
        end
        r_m1[S1_RES] <= n_m1;
        for (int k = S1_RES + 1; k <= LAST; k++) begin
            r_m1[k] <= r_m1[k-1];
        end
    end

    // ------------------------------------------------------ distance path
    assign pt[0] = r_in.point_x;
    assign pt[1] = r_in.point_y;
    assign pt[2] = r_in.point_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c[i] = CW'(pt[i]) - CW'(r_org[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_c[S2_C] <= n_c;
        for (int k = S2_C + 1; k <= S2_X; k++) begin
            r_c[k] <= r_c[k-1];
        end
    end

    // cross product magnitude per axis, |c| when the direction is zero
    for (genvar i = 0; i < 3; i++) begin : g_cross
        localparam int IA = (i + 1) % 3;
        localparam int IB = (i + 2) % 3;
        logic [2*W:0]  pa;
        logic [2*W:0]  pb;
        logic          sa;
        logic          sb;
        logic [XW-1:0] n_xm;
        logic [XW-1:0] r_xm;

        l3d_mult #(.AW(CW), .BW(W), .K(K)) u_mul_a (
            .i_clk (i_clk),
            .i_a   (mag_c(r_c[S2_C][IA])),
            .i_b   (mag_w(r_dir[IB])),
            .o_p   (pa)
        );
        l3d_mult #(.AW(CW), .BW(W), .K(K)) u_mul_b (
            .i_clk (i_clk),
            .i_a   (mag_c(r_c[S2_C][IB])),
            .i_b   (mag_w(r_dir[IA])),
            .o_p   (pb)
        );

        assign sa = r_c[S2_X][IA][CW-1] ^ r_dir[IB][W-1];
        assign sb = r_c[S2_X][IB][CW-1] ^ r_dir[IA][W-1];

        always_comb begin
            if (r_sd[S2_X].deg2) begin
                n_xm = XW'(mag_c(r_c[S2_X][i]));
            end else if (sa != sb) begin
                n_xm = XW'(pa) + XW'(pb);
            end else if (pa >= pb) begin
                n_xm = XW'(pa - pb);
            end else begin
                n_xm = XW'(pb - pa);
            end
        end

        always_ff @(posedge i_clk) begin
            r_xm <= n_xm;
        end

        l3d_mult #(.AW(XW), .BW(XW), .K(K)) u_sq (
            .i_clk (i_clk),
            .i_a   (r_xm),
            .i_b   (r_xm),
            .o_p   (sq[i])
        );

        // |d|^2 terms; user must hold d static while in flight, not enforced
        l3d_mult #(.AW(W), .BW(W), .K(K)) u_dsq (
            .i_clk (i_clk),
            .i_a   (mag_w(r_dir[i])),
            .i_b   (mag_w(r_dir[i])),
            .o_p   (msq[i])
        );
    end

    assign m_n = r_sd[S2_N].deg2 ? MW'(1) : r_msum;

    // quotient floor(n/m): saturation check, then one bit a stage
    always_comb begin
        logic [MW:0]   t;
        logic [MW-1:0] mk;
        n_sat       = (r_n >= (NW'(m_n) << QW));
        n_qd_rem[0] = MW'(r_n >> QW);
        n_qd_dq[0]  = r_n[QW-1:0];
        for (int k = 1; k <= QW; k++) begin
            mk = r_sd[S2_INIT+k-1].deg2 ? MW'(1) : r_msum;
            t  = {r_qd_rem[k-1], r_qd_dq[k-1][QW-1]};
            if (t >= {1'b0, mk}) begin
                n_qd_rem[k] = MW'(t - {1'b0, mk});
                n_qd_dq[k]  = {r_qd_dq[k-1][QW-2:0], 1'b1};
            end else begin
                n_qd_rem[k] = t[MW-1:0];
                n_qd_dq[k]  = {r_qd_dq[k-1][QW-2:0], 1'b0};
            end
        end
    end

    // integer square root of the quotient, one root bit a stage
    always_comb begin
        logic [RW-1:0] pr;
        logic [D-1:0]  ro;
        logic [QW-1:0] pq;
        logic [RW+1:0] r2;
        logic [RW+1:0] tr;
        for (int j = 1; j <= D; j++) begin
            if (j == 1) begin
                pr = '0;
                ro = '0;
                pq = r_qd_dq[QW];
            end else begin
                pr = r_sq_rem[j-1];
                ro = r_sq_root[j-1];
                pq = r_sq_q[j-1];
            end
            r2 = {pr, pq[QW-1:QW-2]};
            tr = {2'b00, ro, 2'b01};
            if (r2 >= tr) begin
                n_sq_rem[j]  = RW'(r2 - tr);
                n_sq_root[j] = {ro[D-2:0], 1'b1};
            end else begin
                n_sq_rem[j]  = r2[RW-1:0];
                n_sq_root[j] = {ro[D-2:0], 1'b0};
            end
            n_sq_q[j] = {pq[QW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        r_msum   <= MW'(msq[0]) + MW'(msq[1]) + MW'(msq[2]);
        r_n      <= NW'(sq[0]) + NW'(sq[1]) + NW'(sq[2]);
        r_qd_rem <= n_qd_rem;
        r_qd_dq  <= n_qd_dq;
        r_sq_rem  <= n_sq_rem;
        r_sq_root <= n_sq_root;
        r_sq_q    <= n_sq_q;
        r_sat[S2_INIT] <= n_sat;
        for (int k = S2_INIT + 1; k <= LAST; k++) begin
            r_sat[k] <= r_sat[k-1];
        end
    end

    // ---------------------------------------------------------- result mux
    always_comb begin
        n_out = '0;
        case (r_sd[LAST].mode)
            l3d_pkg::MODE_POINT: begin
                n_out.result_x  = r_m0[LAST].v[0];
                n_out.result_y  = r_m0[LAST].v[1];
                n_out.result_z  = r_m0[LAST].v[2];
                n_out.saturated = r_m0[LAST].clip;
            end
            l3d_pkg::MODE_ISECT: begin
                if (r_sd[LAST].deg1) begin
                    n_out.degenerate = 1'b1;
                end else begin
                    n_out.result_x  = r_m1[LAST].v[0];
                    n_out.result_y  = r_m1[LAST].v[1];
                    n_out.result_z  = r_sd[LAST].z_res;
                    n_out.saturated = r_m1[LAST].clip | r_sd[LAST].z_clip;
                end
            end
            l3d_pkg::MODE_DIST: begin
                n_out.distance   = r_sat[LAST] ? '1 : r_sq_root[D];
                n_out.degenerate = r_sd[LAST].deg2;
                n_out.saturated  = r_sat[LAST];
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_sd[LAST].vld;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule
